[rtl/core/ihp_pkg.sv]
// Shared types and codes for the indexed min-heap block.
`timescale 1ns / 1ps

package ihp_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  // Status codes reported with every result beat.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } stat_t;

  localparam int VERTEX_BITS = 8;
  localparam int VERTEX_SLOTS = 256;
  localparam int COUNT_OUT_BITS = 9;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [VERTEX_BITS-1:0]  vertex;
    logic signed [31:0]      new_key;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [VERTEX_BITS-1:0]     out_vertex;
    logic signed [31:0]         out_key;
    logic                       in_heap;
    logic                       heap_empty;
    logic [COUNT_OUT_BITS-1:0]  entry_count;
  } out_beat_t;

endpackage

[rtl/core/ihp_front.sv]
// Command front end: accepts beats and queues them for the heap engine.
`timescale 1ns / 1ps

module ihp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ihp_pkg::in_beat_t in_data,
  input  logic             pop,
  output logic             q_vld,
  output ihp_pkg::in_beat_t q_head
);

  localparam int PW = (ihp_pkg::QDEPTH > 1) ? $clog2(ihp_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(ihp_pkg::QDEPTH + 1);

  ihp_pkg::in_beat_t ent_r [ihp_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic push;
  logic do_pop;

  // The queue is full when every entry holds a pending command.
  assign busy   = (fill_r == CW'(ihp_pkg::QDEPTH));
  assign q_vld  = (fill_r != '0);
  assign q_head = ent_r[rd_ptr_r];
  assign push   = start && !busy;
  assign do_pop = pop && q_vld;

  // Pointer and fill bookkeeping with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(ihp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(ihp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

[rtl/core/ihp_exec.sv]
// Heap engine: heap slot memory, position map and the sift sequencer.
`timescale 1ns / 1ps

module ihp_exec #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  input  ihp_pkg::in_beat_t q_head,
  output logic              pop,
  output logic              out_strobe,
  output ihp_pkg::out_beat_t out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VB = ihp_pkg::VERTEX_BITS;
  localparam int HW = VB + KEY_BITS;
  localparam int XW = IW + 2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PRD  = 7'b0000010,
    S_SRD  = 7'b0000100,
    S_XRD  = 7'b0001000,
    S_UP   = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  ihp_pkg::op_t op_r, op_nxt;
  logic [VB-1:0] vtx_r, vtx_nxt;
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [VB-1:0] rvtx_r, rvtx_nxt;
  logic signed [31:0] rkey_r, rkey_nxt;
  logic out_strobe_r, out_strobe_nxt;
  ihp_pkg::out_beat_t out_data_r, out_data_nxt;

  // Heap slot memory: one write port, two registered read ports.
  logic [HW-1:0] hmem [CAPACITY];
  logic h_we;
  logic [IW-1:0] h_waddr, h_ra, h_rb;
  logic [HW-1:0] h_wdata, h_qa, h_qb;

  // Position map memory with a valid bit per vertex.
  logic [CW-1:0] pmem [ihp_pkg::VERTEX_SLOTS];
  logic [ihp_pkg::VERTEX_SLOTS-1:0] pvld_r;
  logic p_we;
  logic [VB-1:0] p_waddr, p_raddr;
  logic [CW-1:0] p_wdata, p_q;
  logic pvld_q;

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    h_qa <= hmem[h_ra];
    h_qb <= hmem[h_rb];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_q    <= pmem[p_raddr];
    pvld_q <= pvld_r[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= '0;
    end else if (p_we) begin
      pvld_r[p_waddr] <= 1'b1;
    end
  end

  // Field views of the read data.
  logic [VB-1:0] qa_vtx, qb_vtx;
  logic signed [KEY_BITS-1:0] qa_key, qb_key;
  assign qa_vtx = h_qa[HW-1 -: VB];
  assign qb_vtx = h_qb[HW-1 -: VB];
  assign qa_key = h_qa[KEY_BITS-1:0];
  assign qb_key = h_qb[KEY_BITS-1:0];

  // Sequencer: lookups, then one tree level per cycle of sift.
  always_comb begin
    logic present;
    logic go_up;
    logic [IW-1:0] up_idx;
    logic [IW-1:0] par;
    logic [CW-1:0] last;
    logic [XW-1:0] lc, rc, bc;
    logic l_ok, r_ok, take;
    logic signed [KEY_BITS-1:0] bk;
    logic [HW-1:0] child;
    logic resp;
    ihp_pkg::stat_t st;
    logic member;
    logic give_root;

    state_nxt      = state_r;
    op_nxt         = op_r;
    vtx_nxt        = vtx_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    p_nxt          = p_r;
    rvtx_nxt       = rvtx_r;
    rkey_nxt       = rkey_r;
    pop            = 1'b0;
    h_we           = 1'b0;
    h_waddr        = idx_r;
    h_wdata        = {vtx_r, key_r};
    h_ra           = '0;
    h_rb           = '0;
    p_we           = 1'b0;
    p_waddr        = vtx_r;
    p_wdata        = CW'(idx_r);
    p_raddr        = q_head.vertex;
    present        = 1'b0;
    go_up          = 1'b0;
    up_idx         = '0;
    par            = IW'((idx_r - IW'(1)) >> 1);
    last           = cnt_r - CW'(1);
    lc             = {1'b0, idx_r, 1'b1};
    rc             = lc + XW'(1);
    bc             = lc;
    l_ok           = 1'b0;
    r_ok           = 1'b0;
    take           = 1'b0;
    bk             = key_r;
    child          = h_qa;
    resp           = 1'b0;
    st             = ihp_pkg::ST_OK;
    member         = 1'b0;
    give_root      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          pop     = 1'b1;
          op_nxt  = ihp_pkg::op_t'(q_head.operation);
          vtx_nxt = q_head.vertex;
          key_nxt = KEY_BITS'(q_head.new_key);
          if (ihp_pkg::op_t'(q_head.operation) == ihp_pkg::OP_EXTRACT) begin
            if (cnt_r == '0) begin
              resp = 1'b1;
              st   = ihp_pkg::ST_EMPTY;
            end else begin
              h_ra      = '0;
              h_rb      = last[IW-1:0];
              state_nxt = S_XRD;
            end
          end else begin
            state_nxt = S_PRD;
          end
        end
      end

      // Position map data is back; fetch the slot it points at.
      S_PRD: begin
        p_nxt     = pvld_q ? p_q : CW'(CAPACITY);
        h_ra      = p_nxt[IW-1:0];
        state_nxt = S_SRD;
      end

      // Slot data is back; decide what the command does.
      S_SRD: begin
        present = (p_r < cnt_r) && (qa_vtx == vtx_r);
        case (op_r)
          ihp_pkg::OP_QUERY: begin
            resp   = 1'b1;
            member = present;
          end
          ihp_pkg::OP_INSERT: begin
            if (present) begin
              resp = 1'b1;
            end else if (cnt_r == CW'(CAPACITY)) begin
              resp = 1'b1;
              st   = ihp_pkg::ST_FULL;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
              go_up   = 1'b1;
              up_idx  = cnt_r[IW-1:0];
            end
          end
          ihp_pkg::OP_DECREASE: begin
            if (!present) begin
              resp = 1'b1;
              st   = ihp_pkg::ST_ABSENT;
            end else begin
              go_up  = 1'b1;
              up_idx = p_r[IW-1:0];
            end
          end
          default: begin
            resp = 1'b1;
          end
        endcase
        if (go_up) begin
          idx_nxt = up_idx;
          if (up_idx == '0) begin
            h_we    = 1'b1;
            h_waddr = '0;
            p_we    = 1'b1;
            p_wdata = '0;
            resp    = 1'b1;
          end else begin
            h_ra      = IW'((up_idx - IW'(1)) >> 1);
            state_nxt = S_UP;
          end
        end
      end

      // Root and last entry are back; last entry becomes the carried item.
      S_XRD: begin
        rvtx_nxt  = qa_vtx;
        rkey_nxt  = 32'(qa_key);
        cnt_nxt   = last;
        p_we      = 1'b1;
        p_waddr   = qa_vtx;
        p_wdata   = last;
        vtx_nxt   = qb_vtx;
        key_nxt   = qb_key;
        idx_nxt   = '0;
        give_root = 1'b1;
        if (last == '0) begin
          resp = 1'b1;
        end else begin
          h_ra      = IW'(1);
          h_rb      = IW'(2);
          state_nxt = S_DN;
        end
      end

      // One level of sift-up: parent moves down while carried key is smaller.
      S_UP: begin
        if (key_r < qa_key) begin
          h_we    = 1'b1;
          h_wdata = h_qa;
          p_we    = 1'b1;
          p_waddr = qa_vtx;
          idx_nxt = par;
          if (par == '0) begin
            state_nxt = S_FIN;
          end else begin
            h_ra = IW'((par - IW'(1)) >> 1);
          end
        end else begin
          h_we = 1'b1;
          p_we = 1'b1;
          resp = 1'b1;
        end
      end

      // Carried item lands at the root.
      S_FIN: begin
        h_we = 1'b1;
        p_we = 1'b1;
        resp = 1'b1;
      end

      // One level of sift-down: smaller child moves up, left wins ties.
      S_DN: begin
        l_ok = lc < XW'(cnt_r);
        r_ok = rc < XW'(cnt_r);
        if (l_ok && (qa_key < bk)) begin
          take  = 1'b1;
          bk    = qa_key;
          bc    = lc;
          child = h_qa;
        end
        if (r_ok && (qb_key < bk)) begin
          take  = 1'b1;
          bc    = rc;
          child = h_qb;
        end
        if (take) begin
          h_we    = 1'b1;
          h_wdata = child;
          p_we    = 1'b1;
          p_waddr = child[HW-1 -: VB];
          idx_nxt = bc[IW-1:0];
          h_ra    = IW'({bc, 1'b1});
          h_rb    = IW'({bc, 1'b1} + (XW + 1)'(1));
        end else begin
          h_we      = 1'b1;
          p_we      = 1'b1;
          resp      = 1'b1;
          give_root = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resp) begin
      state_nxt = S_IDLE;
    end

    // Result beat, built from the count after the command.
    out_strobe_nxt          = resp;
    out_data_nxt.status     = st;
    out_data_nxt.out_vertex = '0;
    out_data_nxt.out_key    = '0;
    if (give_root) begin
      out_data_nxt.out_vertex = rvtx_nxt;
      out_data_nxt.out_key    = rkey_nxt;
    end
    out_data_nxt.in_heap     = member;
    out_data_nxt.heap_empty  = (cnt_nxt == '0);
    out_data_nxt.entry_count = ihp_pkg::COUNT_OUT_BITS'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    vtx_r      <= vtx_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    rvtx_r     <= rvtx_nxt;
    rkey_r     <= rkey_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

[rtl/core/indexed_min_heap_top.sv]
// Top level of the indexed binary min-heap with decrease-key.
//
//  Channel  | Ports                         | Handshake
//  ---------+-------------------------------+--------------------------------
//  command  | start, busy, in_data          | beat taken when start && !busy
//  result   | out_strobe, out_data          | one-cycle strobe, no back-pressure
//
// A command is registered in a two-entry queue, then the engine runs it.
// Query, insert and decrease-key first look up the position map and then the heap
// slot; a sift-up then climbs one tree level per cycle and places the entry.
// Extract reads the root and the last entry; a sift-down then descends one level
// per cycle. The result beat is registered after the last step. Synchronous reset
// empties the heap and marks every position as unset. The result side cannot
// stall; busy rises only when the queue is full.
`timescale 1ns / 1ps

module indexed_min_heap_top #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ihp_pkg::in_beat_t  in_data,
  output logic               out_strobe,
  output ihp_pkg::out_beat_t out_data
);

  logic pop;
  logic q_vld;
  ihp_pkg::in_beat_t q_head;

  ihp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_data(in_data),
    .pop    (pop),
    .q_vld  (q_vld),
    .q_head (q_head)
  );

  ihp_exec #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_head    (q_head),
    .pop       (pop),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule

[rtl/core/ihp_chk.sv]
// Port-level checker for the indexed min-heap, bound to the top level.
`timescale 1ns / 1ps

module ihp_chk #(
  parameter int CAPACITY = 256
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ihp_pkg::in_beat_t  in_data,
  input logic               out_strobe,
  input ihp_pkg::out_beat_t out_data
);

  // No result beat directly after a reset cycle.
  assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result beat right after reset");

  // Empty flag agrees with the entry count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.heap_empty == (out_data.entry_count == '0)))
    else $error("heap_empty disagrees with entry_count");

  // A failed command returns no vertex, no key and no membership.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status != ihp_pkg::ST_OK)) |->
      (out_data.out_vertex == '0 && out_data.out_key == '0 && !out_data.in_heap))
    else $error("payload set on a failed command");

  // The count never exceeds the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_data.entry_count) <= CAPACITY))
    else $error("entry_count above capacity");

endmodule

bind indexed_min_heap_top ihp_chk #(.CAPACITY(CAPACITY)) u_ihp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);
